@@ rtl/aabb_pair_collision_scanner_defines.svh @@
// ============================================================================
// AABB pair collision scanner: assertion macros
// Shared property forms for the checks at the end of the top level.
// ============================================================================
`ifndef AABB_PAIR_COLLISION_SCANNER_DEFINES_SVH
`define AABB_PAIR_COLLISION_SCANNER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define AABB_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("aabb scanner: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define AABB_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("aabb scanner: next-cycle check failed");

`endif

@@ rtl/aabb_pkg.sv @@
// ============================================================================
// AABB scanner package
// Sizes, codes and the command and status bundles shared by the modules.
// ============================================================================
package aabb_pkg;

	// Table and rule matrix dimensions.
	localparam int MAX_SLOTS  = 32;
	localparam int NUM_TYPES  = 11;
	localparam int IDX_W      = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

	// Field widths.
	localparam int SLOT_W     = 5;
	localparam int COORD_W    = 16;
	localparam int SIZE_W     = 12;
	localparam int CLASS_W    = 4;
	localparam int EDGE_W     = COORD_W + 1;
	localparam int RULE_LO_W  = 64;
	localparam int RULE_HI_W  = 57;
	localparam int RULE_W     = RULE_LO_W + RULE_HI_W;
	localparam int RULE_IDX_W = $clog2(RULE_W);
	localparam int PADDR_W    = 4;
	localparam int PDATA_W    = 64;

	// Input action codes.
	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_MOVE   = 2'd2,
		ACT_SCAN   = 2'd3
	} action_t;

	// Result kind codes.
	typedef enum logic [1:0] {
		KIND_ACK   = 2'd0,
		KIND_EVENT = 2'd1,
		KIND_DONE  = 2'd2
	} kind_t;

	// Which result the datapath loads into the output register.
	typedef enum logic [2:0] {
		EMIT_ACK   = 3'd0,
		EMIT_ADDED = 3'd1,
		EMIT_FULL  = 3'd2,
		EMIT_EV_A  = 3'd3,
		EMIT_EV_B  = 3'd4,
		EMIT_DONE  = 3'd5
	} emit_t;

	// Rectangle as held in the table.
	typedef struct packed {
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [SIZE_W-1:0]  width;
		logic [SIZE_W-1:0]  height;
	} rect_t;

	// Collider attributes that a move leaves alone.
	typedef struct packed {
		logic [CLASS_W-1:0] cls;
		logic               listens;
	} attr_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic  capture;
		logic  k_clear;
		logic  k_load_slot;
		logic  k_inc;
		logic  rd_slot;
		logic  load_base;
		logic  add_write;
		logic  move_write;
		logic  remove;
		logic  emit;
		emit_t emit_sel;
	} dp_cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		action_t action;
		logic    slot_in_range;
		logic    slot_ok;
		logic    k_free;
		logic    k_last;
		logic    hit_a;
		logic    hit_b;
	} dp_status_t;

endpackage

@@ rtl/aabb_cfg.sv @@
// ============================================================================
// AABB scanner rule registers
// APB-style register port holding the flattened pair notification matrix.
// ============================================================================
module aabb_cfg
	import aabb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic [RULE_W-1:0]  rules
);

	logic [RULE_LO_W-1:0] rules_lo_q;
	logic [RULE_HI_W-1:0] rules_hi_q;
	logic                 wr_en;
	logic                 sel_hi;

	// Registers sit on 8-byte boundaries; bit 3 picks the register.
	assign wr_en  = psel & penable & pwrite;
	assign sel_hi = paddr[3];

	// Register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rules_lo_q <= '0;
			rules_hi_q <= '0;
		end else if (wr_en) begin
			if (sel_hi) begin
				rules_hi_q <= pwdata[RULE_HI_W-1:0];
			end else begin
				rules_lo_q <= pwdata[RULE_LO_W-1:0];
			end
		end
	end

	// Read back.
	assign prdata = sel_hi ? {{(PDATA_W-RULE_HI_W){1'b0}}, rules_hi_q} : rules_lo_q;
	assign rules  = {rules_hi_q, rules_lo_q};

endmodule

@@ rtl/aabb_dp.sv @@
// ============================================================================
// AABB scanner datapath
// Collider table memories, valid bits, slot counter, overlap and rule test,
// and the result register.
// ============================================================================
module aabb_dp
	import aabb_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [1:0]                action,
	input  logic [SLOT_W-1:0]         slot,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic [SIZE_W-1:0]         size_w,
	input  logic [SIZE_W-1:0]         size_h,
	input  logic [CLASS_W-1:0]        obj_type,
	input  logic                      has_listener,
	input  logic [RULE_W-1:0]         rules,
	input  dp_cmd_t                   cmd,
	output dp_status_t                status,
	output logic [1:0]                kind,
	output logic [SLOT_W-1:0]         slot_a,
	output logic [SLOT_W-1:0]         slot_b,
	output logic                      table_full,
	output logic                      last
);

	// Look up one rule bit; classes outside the matrix read as clear.
	function automatic logic rule_lookup(
		input logic [RULE_W-1:0]  r,
		input logic [CLASS_W-1:0] notified,
		input logic [CLASS_W-1:0] other
	);
		logic [RULE_IDX_W-1:0] bit_idx;
		logic                  in_matrix;
		bit_idx   = RULE_IDX_W'(notified) * RULE_IDX_W'(NUM_TYPES) + RULE_IDX_W'(other);
		in_matrix = (notified < CLASS_W'(NUM_TYPES)) && (other < CLASS_W'(NUM_TYPES));
		return in_matrix ? r[bit_idx] : 1'b0;
	endfunction

	// Captured input transaction.
	action_t            action_q;
	logic [SLOT_W-1:0]  slot_q;
	rect_t              rect_in_q;
	attr_t              attr_in_q;

	// Table storage.
	rect_t              rect_mem [MAX_SLOTS];
	attr_t              attr_mem [MAX_SLOTS];
	rect_t              rect_rd_q;
	attr_t              attr_rd_q;
	logic [MAX_SLOTS-1:0] valid_q;

	// Scan base collider.
	rect_t              base_rect_q;
	attr_t              base_attr_q;

	// Slot counter and addressing.
	logic [IDX_W-1:0]   k_q;
	logic [IDX_W-1:0]   k_next;
	logic [IDX_W-1:0]   slot_idx;
	logic [IDX_W-1:0]   rd_idx;
	logic [IDX_W-1:0]   wr_idx;
	logic               rect_we;
	logic               attr_we;

	// Overlap terms.
	logic signed [EDGE_W-1:0] a_left, a_top, a_right, a_bottom;
	logic signed [EDGE_W-1:0] b_left, b_top, b_right, b_bottom;
	logic                     overlap;
	logic                     pair_live;

	// Result register.
	kind_t              kind_q;
	logic [SLOT_W-1:0]  slot_a_q;
	logic [SLOT_W-1:0]  slot_b_q;
	logic               full_q;
	logic               last_q;

	// Capture the accepted transaction.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q  <= action_t'(action);
			slot_q    <= slot;
			rect_in_q <= '{left: pos_x, top: pos_y, width: size_w, height: size_h};
			attr_in_q <= '{cls: obj_type, listens: has_listener};
		end
	end

	assign slot_idx = slot_q[IDX_W-1:0];
	assign k_next   = IDX_W'(k_q + 1'b1);

	// Slot counter used by the free-slot search and the scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cmd.k_clear) begin
			k_q <= '0;
		end else if (cmd.k_load_slot) begin
			k_q <= slot_idx;
		end else if (cmd.k_inc) begin
			k_q <= k_next;
		end
	end

	// Valid bits: set by an add, cleared by a remove.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (cmd.add_write) begin
				valid_q[k_q] <= 1'b1;
			end
			if (cmd.remove) begin
				valid_q[slot_idx] <= 1'b0;
			end
		end
	end

	// Memory addressing: the read address runs one step ahead when the counter moves.
	assign rd_idx  = cmd.k_inc ? k_next : (cmd.rd_slot ? slot_idx : k_q);
	assign wr_idx  = cmd.add_write ? k_q : slot_idx;
	assign rect_we = cmd.add_write | cmd.move_write;
	assign attr_we = cmd.add_write;

	// Rectangle memory with registered read.
	always_ff @(posedge clk) begin
		if (rect_we) begin
			rect_mem[wr_idx] <= rect_in_q;
		end
		rect_rd_q <= rect_mem[rd_idx];
	end

	// Attribute memory with registered read.
	always_ff @(posedge clk) begin
		if (attr_we) begin
			attr_mem[wr_idx] <= attr_in_q;
		end
		attr_rd_q <= attr_mem[rd_idx];
	end

	// Hold the collider that the scan starts from.
	always_ff @(posedge clk) begin
		if (cmd.load_base) begin
			base_rect_q <= rect_rd_q;
			base_attr_q <= attr_rd_q;
		end
	end

	// Closed-extent overlap between the base and the slot under the counter.
	always_comb begin
		a_left   = {base_rect_q.left[COORD_W-1], base_rect_q.left};
		a_top    = {base_rect_q.top[COORD_W-1], base_rect_q.top};
		a_right  = a_left + {{(EDGE_W-SIZE_W){1'b0}}, base_rect_q.width};
		a_bottom = a_top + {{(EDGE_W-SIZE_W){1'b0}}, base_rect_q.height};
		b_left   = {rect_rd_q.left[COORD_W-1], rect_rd_q.left};
		b_top    = {rect_rd_q.top[COORD_W-1], rect_rd_q.top};
		b_right  = b_left + {{(EDGE_W-SIZE_W){1'b0}}, rect_rd_q.width};
		b_bottom = b_top + {{(EDGE_W-SIZE_W){1'b0}}, rect_rd_q.height};
		overlap  = !((b_left > a_right) || (b_top > a_bottom) ||
			(a_left > b_right) || (a_top > b_bottom));
	end

	assign pair_live = valid_q[k_q] & overlap;

	// Status to the controller.
	always_comb begin
		status.action        = action_q;
		status.slot_in_range = ({1'b0, slot_q} < (SLOT_W+1)'(MAX_SLOTS));
		status.slot_ok       = status.slot_in_range & valid_q[slot_idx];
		status.k_free        = ~valid_q[k_q];
		status.k_last        = (k_q == IDX_W'(MAX_SLOTS - 1));
		status.hit_a         = pair_live & base_attr_q.listens &
			rule_lookup(rules, base_attr_q.cls, attr_rd_q.cls);
		status.hit_b         = pair_live & attr_rd_q.listens &
			rule_lookup(rules, attr_rd_q.cls, base_attr_q.cls);
	end

	// Result register load.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q   <= KIND_ACK;
			slot_a_q <= '0;
			slot_b_q <= '0;
			full_q   <= 1'b0;
			last_q   <= 1'b1;
			unique case (cmd.emit_sel)
				EMIT_ACK: begin
				end
				EMIT_ADDED: begin
					slot_a_q <= SLOT_W'(k_q);
				end
				EMIT_FULL: begin
					full_q <= 1'b1;
				end
				EMIT_EV_A: begin
					kind_q   <= KIND_EVENT;
					slot_a_q <= SLOT_W'(slot_idx);
					slot_b_q <= SLOT_W'(k_q);
					last_q   <= 1'b0;
				end
				EMIT_EV_B: begin
					kind_q   <= KIND_EVENT;
					slot_a_q <= SLOT_W'(k_q);
					slot_b_q <= SLOT_W'(slot_idx);
					last_q   <= 1'b0;
				end
				EMIT_DONE: begin
					kind_q <= KIND_DONE;
				end
				default: begin
				end
			endcase
		end
	end

	assign kind       = kind_q;
	assign slot_a     = slot_a_q;
	assign slot_b     = slot_b_q;
	assign table_full = full_q;
	assign last       = last_q;

endmodule

@@ rtl/aabb_ctrl.sv @@
// ============================================================================
// AABB scanner controller
// Sequences each transaction through decode, then acknowledge, free-slot search
// or pair scan, and owns the result valid flag.
// ============================================================================
module aabb_ctrl
	import aabb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	output logic       res_valid,
	input  logic       res_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [6:0] {
		ST_IDLE      = 7'b0000001,
		ST_DECODE    = 7'b0000010,
		ST_ACK       = 7'b0000100,
		ST_ADD       = 7'b0001000,
		ST_SCAN_BASE = 7'b0010000,
		ST_SCAN      = 7'b0100000,
		ST_DONE      = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   res_valid_q;
	logic   sent_a_q, sent_a_d;
	logic   out_free;
	logic   advance;

	// The result register can take a new transaction when empty or draining.
	assign out_free  = ~res_valid_q | ~res_stall;
	assign cmd_stall = (state_q != ST_IDLE);
	assign res_valid = res_valid_q;

	// Next state and commands.
	always_comb begin
		state_d      = state_q;
		sent_a_d     = sent_a_q;
		advance      = 1'b0;
		cmd          = '0;
		cmd.emit_sel = EMIT_ACK;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (status.action)
					ACT_ADD: begin
						cmd.k_clear = 1'b1;
						state_d     = ST_ADD;
					end
					ACT_REMOVE: begin
						cmd.remove = status.slot_in_range;
						state_d    = ST_ACK;
					end
					ACT_MOVE: begin
						cmd.move_write = status.slot_ok;
						state_d        = ST_ACK;
					end
					ACT_SCAN: begin
						if (status.slot_ok) begin
							cmd.rd_slot     = 1'b1;
							cmd.k_load_slot = 1'b1;
							state_d         = ST_SCAN_BASE;
						end else begin
							state_d = ST_DONE;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_ACK: begin
				if (out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EMIT_ACK;
					state_d      = ST_IDLE;
				end
			end
			ST_ADD: begin
				// Walk the slots from the bottom until a free one turns up or the last is reached.
				if (status.k_free) begin
					if (out_free) begin
						cmd.add_write = 1'b1;
						cmd.emit      = 1'b1;
						cmd.emit_sel  = EMIT_ADDED;
						state_d       = ST_IDLE;
					end
				end else if (status.k_last) begin
					if (out_free) begin
						cmd.emit     = 1'b1;
						cmd.emit_sel = EMIT_FULL;
						state_d      = ST_IDLE;
					end
				end else begin
					cmd.k_inc = 1'b1;
				end
			end
			ST_SCAN_BASE: begin
				cmd.load_base = 1'b1;
				sent_a_d      = 1'b0;
				if (status.k_last) begin
					state_d = ST_DONE;
				end else begin
					cmd.k_inc = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// Up to two events per pair: base notified first, then the other slot.
				if (status.hit_a && !sent_a_q) begin
					if (out_free) begin
						cmd.emit     = 1'b1;
						cmd.emit_sel = EMIT_EV_A;
						if (status.hit_b) begin
							sent_a_d = 1'b1;
						end else begin
							advance = 1'b1;
						end
					end
				end else if (status.hit_b) begin
					if (out_free) begin
						cmd.emit     = 1'b1;
						cmd.emit_sel = EMIT_EV_B;
						advance      = 1'b1;
					end
				end else begin
					advance = 1'b1;
				end
				if (advance) begin
					sent_a_d = 1'b0;
					if (status.k_last) begin
						state_d = ST_DONE;
					end else begin
						cmd.k_inc = 1'b1;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.emit     = 1'b1;
					cmd.emit_sel = EMIT_DONE;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sent_a_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			sent_a_q    <= sent_a_d;
			res_valid_q <= cmd.emit | (res_valid_q & res_stall);
		end
	end

endmodule

@@ rtl/aabb_pair_collision_scanner.sv @@
// ============================================================================
// AABB pair collision scanner
// Table of rectangle colliders with add, remove, move and a pair scan that
// reports rule-filtered overlap events followed by a done transaction.
// ============================================================================
//
//   Port group    Direction  Handshake            Payload
//   cmd           in         cmd_valid/cmd_stall  action slot pos_x pos_y size_w size_h
//                                                 obj_type has_listener
//   res           out        res_valid/res_stall  kind slot_a slot_b table_full last
//   apb           in/out     psel/penable/pready  paddr pwdata prdata
//
// Remove and move go from acceptance through decode to an acknowledge state.
// Add walks up from slot 0 past occupied slots to the first free one, or reports full.
// A scan of slot i compares it with each slot above i; the slot memory gives one entry
// a cycle unless a stalled result or a pair notifying both sides holds the counter.
// One transaction is in flight at a time; a stalled result holds the sequencer.
// Reset clears the valid bits and rule registers at once; no clearing pass.
//
`include "aabb_pair_collision_scanner_defines.svh"

module aabb_pair_collision_scanner
	import aabb_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	// Command channel
	input  logic                      cmd_valid,
	output logic                      cmd_stall,
	input  logic [1:0]                action,
	input  logic [SLOT_W-1:0]         slot,
	input  logic signed [COORD_W-1:0] pos_x,
	input  logic signed [COORD_W-1:0] pos_y,
	input  logic [SIZE_W-1:0]         size_w,
	input  logic [SIZE_W-1:0]         size_h,
	input  logic [CLASS_W-1:0]        obj_type,
	input  logic                      has_listener,
	// Result channel
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic [1:0]                kind,
	output logic [SLOT_W-1:0]         slot_a,
	output logic [SLOT_W-1:0]         slot_b,
	output logic                      table_full,
	output logic                      last,
	// Register port
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [PADDR_W-1:0]        paddr,
	input  logic [PDATA_W-1:0]        pwdata,
	output logic [PDATA_W-1:0]        prdata,
	output logic                      pready
);

	logic [RULE_W-1:0] rules;
	dp_cmd_t           dp_cmd;
	dp_status_t        dp_status;

	assign pready = 1'b1;

	// Rule registers.
	aabb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.rules   (rules)
	);

	// Sequencer.
	aabb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.status    (dp_status),
		.cmd       (dp_cmd)
	);

	// Table and compare datapath.
	aabb_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.action       (action),
		.slot         (slot),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.size_w       (size_w),
		.size_h       (size_h),
		.obj_type     (obj_type),
		.has_listener (has_listener),
		.rules        (rules),
		.cmd          (dp_cmd),
		.status       (dp_status),
		.kind         (kind),
		.slot_a       (slot_a),
		.slot_b       (slot_b),
		.table_full   (table_full),
		.last         (last)
	);

	// A result is only loaded when the output register is free or draining.
	`AABB_ASSERT_NOW(a_emit_into_free, dp_cmd.emit, !res_valid || !res_stall)
	// An accepted command raises the stall in the next cycle, blocking the next one.
	`AABB_ASSERT_NEXT(a_one_in_flight, cmd_valid && !cmd_stall, cmd_stall)
	// Events pair two different slots and never close a transaction.
	`AABB_ASSERT_NOW(a_event_shape, res_valid && kind == KIND_EVENT, !last && slot_a != slot_b)

endmodule

@@ bench/aabb_pair_collision_scanner_tb.sv @@
// ============================================================================
// AABB pair collision scanner testbench
// Sends add, remove, move and scan commands under random sender gaps and
// receiver stalls. A shadow copy of the collider table and the notify rules
// predicts every acknowledge, collision event and done transaction. Each
// result is checked field by field, in order, against the oldest prediction.
// ============================================================================
module aabb_pair_collision_scanner_tb;
	import aabb_pkg::*;

	// One command transaction as the sender builds it.
	typedef struct {
		action_t                   act;
		logic [SLOT_W-1:0]         slot;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [SIZE_W-1:0]         w;
		logic [SIZE_W-1:0]         h;
		logic [CLASS_W-1:0]        cls;
		logic                      listens;
	} collider_cmd_t;

	// One result transaction as the block should produce it.
	typedef struct {
		kind_t             kind;
		logic [SLOT_W-1:0] a;
		logic [SLOT_W-1:0] b;
		logic              full;
		logic              last;
	} scan_result_t;

	// Receiver stall patterns.
	typedef enum int {
		RX_READY,
		RX_COIN,
		RX_RARE,
		RX_PERIODIC
	} stall_pattern_t;

	localparam logic [PADDR_W-1:0] ADDR_RULES_LOW  = 4'd0;
	localparam logic [PADDR_W-1:0] ADDR_RULES_HIGH = 4'd8;
	localparam int                 DRAIN_CYCLES    = 80;
	localparam logic [PDATA_W-1:0] RULES_ALL       = '1;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cmd_valid = 1'b0;
	logic                      cmd_stall;
	logic [1:0]                action = ACT_ADD;
	logic [SLOT_W-1:0]         slot = '0;
	logic signed [COORD_W-1:0] pos_x = '0;
	logic signed [COORD_W-1:0] pos_y = '0;
	logic [SIZE_W-1:0]         size_w = '0;
	logic [SIZE_W-1:0]         size_h = '0;
	logic [CLASS_W-1:0]        obj_type = '0;
	logic                      has_listener = 1'b0;
	logic                      res_valid;
	logic                      res_stall = 1'b0;
	logic [1:0]                kind;
	logic [SLOT_W-1:0]         slot_a;
	logic [SLOT_W-1:0]         slot_b;
	logic                      table_full;
	logic                      last;
	logic                      psel = 1'b0;
	logic                      penable = 1'b0;
	logic                      pwrite = 1'b0;
	logic [PADDR_W-1:0]        paddr = '0;
	logic [PDATA_W-1:0]        pwdata = '0;
	logic [PDATA_W-1:0]        prdata;
	logic                      pready;

	// Shadow collider table and notify matrix.
	logic                      tbl_valid   [MAX_SLOTS];
	logic signed [COORD_W-1:0] tbl_left    [MAX_SLOTS];
	logic signed [COORD_W-1:0] tbl_top     [MAX_SLOTS];
	logic [SIZE_W-1:0]         tbl_width   [MAX_SLOTS];
	logic [SIZE_W-1:0]         tbl_height  [MAX_SLOTS];
	logic [CLASS_W-1:0]        tbl_class   [MAX_SLOTS];
	logic                      tbl_listens [MAX_SLOTS];
	logic [RULE_W-1:0]         notify_rules = '0;

	scan_result_t   pending_results [$];
	int             n_errors = 0;
	int             n_cmds = 0;
	int             n_results = 0;
	int             n_events = 0;
	int             n_full = 0;
	int             n_rule_sets = 0;
	int             burst_left = 0;
	stall_pattern_t stall_pattern = RX_READY;
	int             stall_left = 0;

	aabb_pair_collision_scanner dut (.*);

	// Clock with a period of 8.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Rule lookup; classes outside the matrix never notify.
	function automatic logic notify_allowed(logic [CLASS_W-1:0] heard,
		logic [CLASS_W-1:0] other);
		int bit_idx;
		if (heard >= NUM_TYPES || other >= NUM_TYPES)
			return 1'b0;
		bit_idx = int'(heard) * NUM_TYPES + int'(other);
		return notify_rules[bit_idx];
	endfunction

	// Closed-extent overlap at full precision, so touching edges count.
	function automatic logic rects_meet(int i, int k);
		int i_right, i_bottom, k_right, k_bottom;
		i_right  = int'(tbl_left[i]) + int'(tbl_width[i]);
		i_bottom = int'(tbl_top[i]) + int'(tbl_height[i]);
		k_right  = int'(tbl_left[k]) + int'(tbl_width[k]);
		k_bottom = int'(tbl_top[k]) + int'(tbl_height[k]);
		if (int'(tbl_left[k]) > i_right || int'(tbl_top[k]) > i_bottom)
			return 1'b0;
		if (int'(tbl_left[i]) > k_right || int'(tbl_top[i]) > k_bottom)
			return 1'b0;
		return 1'b1;
	endfunction

	function automatic void push_result(kind_t k, int a, int b, logic full, logic fin);
		scan_result_t r;
		r.kind = k;
		r.a    = SLOT_W'(a);
		r.b    = SLOT_W'(b);
		r.full = full;
		r.last = fin;
		pending_results.push_back(r);
	endfunction

	// Update the shadow table for one accepted command and queue its results.
	function automatic void predict_collider_cmd(collider_cmd_t c);
		int free_slot;
		int s;
		free_slot = -1;
		s = int'(c.slot);
		case (c.act)
		ACT_ADD: begin
			for (int j = 0; j < MAX_SLOTS; j++)
				if (!tbl_valid[j] && free_slot < 0)
					free_slot = j;
			if (free_slot >= 0) begin
				tbl_valid[free_slot]   = 1'b1;
				tbl_left[free_slot]    = c.x;
				tbl_top[free_slot]     = c.y;
				tbl_width[free_slot]   = c.w;
				tbl_height[free_slot]  = c.h;
				tbl_class[free_slot]   = c.cls;
				tbl_listens[free_slot] = c.listens;
				push_result(KIND_ACK, free_slot, 0, 1'b0, 1'b1);
			end else begin
				n_full++;
				push_result(KIND_ACK, 0, 0, 1'b1, 1'b1);
			end
		end
		ACT_REMOVE: begin
			tbl_valid[s] = 1'b0;
			push_result(KIND_ACK, 0, 0, 1'b0, 1'b1);
		end
		ACT_MOVE: begin
			// A move of a free slot leaves the table alone.
			if (tbl_valid[s]) begin
				tbl_left[s]   = c.x;
				tbl_top[s]    = c.y;
				tbl_width[s]  = c.w;
				tbl_height[s] = c.h;
			end
			push_result(KIND_ACK, 0, 0, 1'b0, 1'b1);
		end
		default: begin
			if (tbl_valid[s]) begin
				for (int k = s + 1; k < MAX_SLOTS; k++) begin
					if (tbl_valid[k] && rects_meet(s, k)) begin
						if (tbl_listens[s] && notify_allowed(tbl_class[s], tbl_class[k]))
							push_result(KIND_EVENT, s, k, 1'b0, 1'b0);
						if (tbl_listens[k] && notify_allowed(tbl_class[k], tbl_class[s]))
							push_result(KIND_EVENT, k, s, 1'b0, 1'b0);
					end
				end
			end
			push_result(KIND_DONE, 0, 0, 1'b0, 1'b1);
		end
		endcase
	endfunction

	function automatic collider_cmd_t make_cmd(action_t act, int s, int x, int y,
		int w, int h, int cls, logic listens);
		collider_cmd_t c;
		c.act     = act;
		c.slot    = SLOT_W'(s);
		c.x       = COORD_W'(x);
		c.y       = COORD_W'(y);
		c.w       = SIZE_W'(w);
		c.h       = SIZE_W'(h);
		c.cls     = CLASS_W'(cls);
		c.listens = listens;
		return c;
	endfunction

	// Mostly well-formed traffic in a small arena, with some raw noise.
	function automatic collider_cmd_t random_collider_cmd();
		collider_cmd_t c;
		int            live [$];
		int            pick;
		int            add_weight;
		for (int j = 0; j < MAX_SLOTS; j++)
			if (tbl_valid[j])
				live.push_back(j);
		c.slot    = SLOT_W'($urandom);
		c.x       = COORD_W'(int'($urandom_range(0, 600)) - 300);
		c.y       = COORD_W'(int'($urandom_range(0, 600)) - 300);
		c.w       = SIZE_W'($urandom_range(0, 200));
		c.h       = SIZE_W'($urandom_range(0, 200));
		c.cls     = ($urandom_range(0, 9) == 0) ? CLASS_W'($urandom_range(NUM_TYPES, 15))
			: CLASS_W'($urandom_range(0, NUM_TYPES - 1));
		c.listens = ($urandom_range(0, 3) != 0);
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			c.act = action_t'($urandom_range(0, 3));
			c.x   = COORD_W'($urandom);
			c.y   = COORD_W'($urandom);
			c.w   = SIZE_W'($urandom);
			c.h   = SIZE_W'($urandom);
			c.cls = CLASS_W'($urandom);
			return c;
		end
		add_weight = (live.size() < 4) ? 70 : (live.size() > 26) ? 10 : 30;
		pick = $urandom_range(0, 99);
		if (pick < add_weight)
			c.act = ACT_ADD;
		else if (pick < add_weight + (100 - add_weight) / 2)
			c.act = ACT_SCAN;
		else if ($urandom_range(0, 1) == 0)
			c.act = ACT_MOVE;
		else
			c.act = ACT_REMOVE;
		if (c.act != ACT_ADD && live.size() != 0 && $urandom_range(0, 9) != 0)
			c.slot = SLOT_W'(live[$urandom_range(0, live.size() - 1)]);
		return c;
	endfunction

	// Drive one command and hold it until the block accepts it.
	task automatic send_collider_cmd(collider_cmd_t c);
		@(negedge clk);
		cmd_valid    = 1'b1;
		action       = c.act;
		slot         = c.slot;
		pos_x        = c.x;
		pos_y        = c.y;
		size_w       = c.w;
		size_h       = c.h;
		obj_type     = c.cls;
		has_listener = c.listens;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		predict_collider_cmd(c);
		n_cmds++;
		// Sender works in bursts with random gaps between them.
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			cmd_valid = 1'b0;
			repeat ($urandom_range(0, 7))
				@(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
				: $urandom_range(0, 6);
		end
	endtask

	// Stop sending and wait for every predicted result.
	task automatic wait_results_drained();
		@(negedge clk);
		cmd_valid  = 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_rule_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		pwrite  = 1'b1;
		penable = 1'b0;
		paddr   = addr;
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (addr == ADDR_RULES_LOW)
			notify_rules[RULE_LO_W-1:0] = value;
		else
			notify_rules[RULE_W-1:RULE_LO_W] = value[RULE_HI_W-1:0];
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// Rules change only while the block is idle.
	task automatic set_pair_rules(logic [PDATA_W-1:0] low, logic [PDATA_W-1:0] high);
		wait_results_drained();
		repeat (10)
			@(posedge clk);
		write_rule_reg(ADDR_RULES_LOW, low);
		write_rule_reg(ADDR_RULES_HIGH, high);
		n_rule_sets++;
	endtask

	task automatic clear_table();
		for (int j = 0; j < MAX_SLOTS; j++)
			if (tbl_valid[j])
				send_collider_cmd(make_cmd(ACT_REMOVE, j, 0, 0, 0, 0, 0, 1'b0));
	endtask

	// Commands on an empty table and field extremes with all rules clear.
	task automatic test_basic_commands();
		send_collider_cmd(make_cmd(ACT_SCAN, 0, 0, 0, 0, 0, 0, 1'b0));
		send_collider_cmd(make_cmd(ACT_REMOVE, 31, 0, 0, 0, 0, 0, 1'b0));
		send_collider_cmd(make_cmd(ACT_MOVE, 7, -32768, 32767, 4095, 4095, 15, 1'b1));
		send_collider_cmd(make_cmd(ACT_ADD, 31, -32768, -32768, 4095, 4095, 15, 1'b1));
		send_collider_cmd(make_cmd(ACT_ADD, 0, 32767, 32767, 4095, 4095, 10, 1'b0));
		send_collider_cmd(make_cmd(ACT_ADD, 21, 0, 0, 0, 0, 0, 1'b1));
		send_collider_cmd(make_cmd(ACT_SCAN, 0, 0, 0, 0, 0, 0, 1'b0));
		send_collider_cmd(make_cmd(ACT_MOVE, 1, -1, -1, 0, 0, 5, 1'b1));
		send_collider_cmd(make_cmd(ACT_SCAN, 9, 0, 0, 0, 0, 0, 1'b0));
		clear_table();
		wait_results_drained();
	endtask

	// Touching edges, one-sided listeners, classes outside the matrix, and
	// edges at the coordinate limits.
	task automatic test_touching_edges();
		set_pair_rules(RULES_ALL, RULES_ALL);
		send_collider_cmd(make_cmd(ACT_ADD, 0, 0, 0, 10, 10, 3, 1'b1));
		send_collider_cmd(make_cmd(ACT_ADD, 0, 10, 10, 5, 5, 7, 1'b1));
		send_collider_cmd(make_cmd(ACT_ADD, 0, 11, 0, 4, 4, 2, 1'b1));
		send_collider_cmd(make_cmd(ACT_ADD, 0, -5, 10, 5, 0, 1, 1'b0));
		send_collider_cmd(make_cmd(ACT_ADD, 0, 2, 2, 1, 1, 12, 1'b1));
		for (int s = 0; s < 4; s++)
			send_collider_cmd(make_cmd(ACT_SCAN, s, 0, 0, 0, 0, 0, 1'b0));
		send_collider_cmd(make_cmd(ACT_MOVE, 1, 28672, 28672, 4095, 4095, 0, 1'b0));
		send_collider_cmd(make_cmd(ACT_ADD, 0, 32767, 32767, 0, 0, 0, 1'b1));
		send_collider_cmd(make_cmd(ACT_SCAN, 1, 0, 0, 0, 0, 0, 1'b0));
		send_collider_cmd(make_cmd(ACT_MOVE, 2, -32768, -32768, 4095, 4095, 0, 1'b0));
		send_collider_cmd(make_cmd(ACT_MOVE, 3, -28673, -28673, 0, 0, 0, 1'b0));
		send_collider_cmd(make_cmd(ACT_SCAN, 2, 0, 0, 0, 0, 0, 1'b0));
		clear_table();
		wait_results_drained();
	endtask

	// Fill every slot around a common point: full-table adds and the
	// longest scan, where every pair notifies both ways.
	task automatic test_table_full();
		set_pair_rules(RULES_ALL, RULES_ALL);
		for (int j = 0; j < MAX_SLOTS; j++)
			send_collider_cmd(make_cmd(ACT_ADD, $urandom, -int'($urandom_range(0, 100)),
				-int'($urandom_range(0, 100)), $urandom_range(100, 400),
				$urandom_range(100, 400), j % NUM_TYPES, 1'b1));
		send_collider_cmd(make_cmd(ACT_ADD, 0, 0, 0, 1, 1, 4, 1'b1));
		send_collider_cmd(make_cmd(ACT_SCAN, 0, 0, 0, 0, 0, 0, 1'b0));
		send_collider_cmd(make_cmd(ACT_SCAN, MAX_SLOTS - 1, 0, 0, 0, 0, 0, 1'b0));
		// Hold the sender until the long scan has fully drained.
		wait_results_drained();
		send_collider_cmd(make_cmd(ACT_REMOVE, 17, 0, 0, 0, 0, 0, 1'b0));
		send_collider_cmd(make_cmd(ACT_ADD, 0, 50, 50, 9, 9, 6, 1'b0));
		send_collider_cmd(make_cmd(ACT_ADD, 0, 50, 50, 9, 9, 6, 1'b1));
		send_collider_cmd(make_cmd(ACT_SCAN, 3, 0, 0, 0, 0, 0, 1'b0));
		clear_table();
		wait_results_drained();
	endtask

	// Random command traffic under one rule setting.
	task automatic test_random_traffic(logic [PDATA_W-1:0] low, logic [PDATA_W-1:0] high,
		int count);
		set_pair_rules(low, high);
		for (int n = 0; n < count; n++) begin
			send_collider_cmd(random_collider_cmd());
			if (n == count / 2 && $urandom_range(0, 1) == 0)
				wait_results_drained();
		end
		wait_results_drained();
	endtask

	function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			n_errors++;
			$error("%s mismatch: expected %0d, actual %0d", field, want, got);
		end
	endfunction

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		scan_result_t want;
		if (arst_n && res_valid && !res_stall) begin
			n_results++;
			if (pending_results.size() == 0) begin
				n_errors++;
				$error("unexpected result: kind %0d slot_a %0d slot_b %0d",
					kind, slot_a, slot_b);
			end else begin
				want = pending_results.pop_front();
				if (want.kind == KIND_EVENT)
					n_events++;
				check_field("kind", 32'(want.kind), 32'(kind));
				check_field("slot_a", 32'(want.a), 32'(slot_a));
				check_field("slot_b", 32'(want.b), 32'(slot_b));
				check_field("table_full", 32'(want.full), 32'(table_full));
				check_field("last", 32'(want.last), 32'(last));
			end
		end
	end

	// Receiver stalls, switching among patterns of random length.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_pattern = stall_pattern_t'($urandom_range(0, 3));
			stall_left    = $urandom_range(20, 150);
		end else begin
			stall_left--;
		end
		case (stall_pattern)
		RX_READY: res_stall = 1'b0;
		RX_COIN:  res_stall = ($urandom_range(0, 1) == 0);
		RX_RARE:  res_stall = ($urandom_range(0, 7) == 0);
		default:  res_stall = (stall_left % 8) < 5;
		endcase
	end

	// Main sequence.
	initial begin
		for (int j = 0; j < MAX_SLOTS; j++)
			tbl_valid[j] = 1'b0;
		repeat (8)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_basic_commands();
		test_touching_edges();
		test_table_full();
		test_random_traffic({$urandom, $urandom}, {$urandom, $urandom}, 54);
		test_random_traffic(RULES_ALL, RULES_ALL, 54);
		test_random_traffic(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 54);
		test_random_traffic('0, {$urandom, $urandom}, 54);

		wait_results_drained();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (pending_results.size() != 0) begin
			n_errors++;
			$error("%0d predicted results never arrived", pending_results.size());
		end
		$display("Ran %0d commands over %0d rule settings, including a full table.",
			n_cmds, n_rule_sets);
		$display("Checked %0d results: %0d collision events, %0d adds refused as full.",
			n_results, n_events, n_full);
		if (n_errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#16000000;
		$display("status: fail");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/aabb_pkg.sv
rtl/aabb_cfg.sv
rtl/aabb_dp.sv
rtl/aabb_ctrl.sv
rtl/aabb_pair_collision_scanner.sv
bench/aabb_pair_collision_scanner_tb.sv
